// ===== rtl/owd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package owd_pkg;

    // Body velocity width
    localparam int VEL_WIDTH = 16;

    // Field and register widths
    localparam int GYRO_W   = 16;
    localparam int GAIN_W   = 16;
    localparam int LIM_W    = 15;
    localparam int VOLT_W   = 16;
    localparam int IDLE_W   = 10;
    localparam int NUM_W    = 24;
    localparam int PER_W    = 16;
    localparam int COEF_W   = 17;

    // Q.16 sum width and width of the truncated wheel target
    localparam int Q_W = ((VEL_WIDTH > 16) ? VEL_WIDTH : 16) + 20;
    localparam int T_W = Q_W - 16;

    // Kinematic coefficient sqrt(3)/2 in Q.16, rounded to nearest
    localparam logic signed [COEF_W-1:0] COEF_SQRT3_2 = 17'sd56756;

    localparam logic [PER_W-1:0] PERIOD_MAX = {PER_W{1'b1}};

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_GAIN        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LIMIT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_VOLTAGE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_NUMERATOR = 3'd4;

    // Register reset values
    localparam logic [GAIN_W-1:0] RST_GYRO_GAIN        = 16'd262;
    localparam logic [LIM_W-1:0]  RST_DRIVE_LIMIT      = 15'd5000;
    localparam logic [VOLT_W-1:0] RST_LOW_VOLTAGE      = 16'd1100;
    localparam logic [IDLE_W-1:0] RST_IDLE_LIMIT       = 10'd200;
    localparam logic [NUM_W-1:0]  RST_PERIOD_NUMERATOR = 24'd1000000;

    // Wheel selection
    localparam int NUM_WHEELS = 3;
    localparam int WHEEL_W    = 2;
    localparam logic [WHEEL_W-1:0] WHEEL_A = 2'd0;
    localparam logic [WHEEL_W-1:0] WHEEL_C = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULT,
        ST_SUM,
        ST_CLAMP,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT,
        ST_OUT_OFF
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic               load_in;
        logic               mult;
        logic               sum;
        logic               clamp;
        logic               div_start;
        logic               quot_store;
        logic               out_load;
        logic               out_off;
        logic [WHEEL_W-1:0] wheel;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic low_batt;
        logic div_done;
    } dp_stat_t;

    // Input beat payload
    typedef struct packed {
        logic signed [VEL_WIDTH-1:0] vel_x;
        logic signed [VEL_WIDTH-1:0] vel_y;
        logic signed [VEL_WIDTH-1:0] vel_rot;
        logic signed [GYRO_W-1:0]    gyro_z;
        logic [VOLT_W-1:0]           battery_voltage;
    } in_beat_t;

    // Output beat payload
    typedef struct packed {
        logic [PER_W-1:0] period_a;
        logic [PER_W-1:0] period_b;
        logic [PER_W-1:0] period_c;
        logic             dir_a;
        logic             dir_b;
        logic             dir_c;
        logic             driver_enable;
        logic             shutdown;
    } out_beat_t;

endpackage

`default_nettype wire

// ===== rtl/owd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Velocity command channel
interface owd_in_if;
    import owd_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [VEL_WIDTH-1:0] vel_x;
    logic signed [VEL_WIDTH-1:0] vel_y;
    logic signed [VEL_WIDTH-1:0] vel_rot;
    logic signed [GYRO_W-1:0]    gyro_z;
    logic [VOLT_W-1:0]           battery_voltage;

    modport source (
        output valid, vel_x, vel_y, vel_rot, gyro_z, battery_voltage,
        input  ready
    );

    modport sink (
        input  valid, vel_x, vel_y, vel_rot, gyro_z, battery_voltage,
        output ready
    );
endinterface

// Wheel drive channel
interface owd_out_if;
    import owd_pkg::*;

    logic             valid;
    logic             ready;
    logic [PER_W-1:0] period_a;
    logic [PER_W-1:0] period_b;
    logic [PER_W-1:0] period_c;
    logic             dir_a;
    logic             dir_b;
    logic             dir_c;
    logic             driver_enable;
    logic             shutdown;

    modport source (
        output valid, period_a, period_b, period_c, dir_a, dir_b, dir_c,
               driver_enable, shutdown,
        input  ready
    );

    modport sink (
        input  valid, period_a, period_b, period_c, dir_a, dir_b, dir_c,
               driver_enable, shutdown,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/owd_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle
module owd_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [owd_pkg::NUM_W-1:0]   dividend,
    input  wire logic [owd_pkg::LIM_W-1:0]   divisor,
    output logic                             done,
    output logic [owd_pkg::NUM_W-1:0]        quotient
);
    import owd_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [LIM_W-1:0] rem_reg, rem_next;
    logic [LIM_W-1:0] dsor_reg, dsor_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [LIM_W:0]   rem_shift;
    logic             fits;

    // Shift in the next dividend bit and try the subtraction
    assign rem_shift = {rem_reg, quot_reg[NUM_W-1]};
    assign fits      = rem_shift >= {1'b0, dsor_reg};

    always_comb
    begin
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        dsor_next  = dsor_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            quot_next  = dividend;
            rem_next   = '0;
            dsor_next  = divisor;
            count_next = CNT_W'(NUM_W);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            quot_next  = {quot_reg[NUM_W-2:0], fits};
            rem_next   = fits ? LIM_W'(rem_shift - {1'b0, dsor_reg}) : LIM_W'(rem_shift);
            count_next = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsor_reg <= dsor_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

    // Never restart a division in flight
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    // Done is a single-cycle pulse
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held");

    // Done follows the last step
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a step");

endmodule

`default_nettype wire

// ===== rtl/owd_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module owd_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire owd_pkg::dp_cmd_t              cmd,
    output owd_pkg::dp_stat_t                  stat,
    input  wire owd_pkg::in_beat_t             in_beat,
    output owd_pkg::out_beat_t                 out_beat,
    input  wire logic                          cfg_we,
    input  wire logic [owd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [owd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import owd_pkg::*;

    // Configuration registers
    logic [GAIN_W-1:0] gyro_gain_reg;
    logic [LIM_W-1:0]  drive_limit_reg;
    logic [VOLT_W-1:0] low_voltage_reg;
    logic [IDLE_W-1:0] idle_limit_reg;
    logic [NUM_W-1:0]  period_num_reg;

    // Captured input beat
    logic signed [VEL_WIDTH-1:0] vx_reg, vy_reg, vr_reg;
    logic signed [GYRO_W-1:0]    gz_reg;
    logic [VOLT_W-1:0]           volt_reg;

    // Products
    logic signed [GYRO_W+GAIN_W:0]         gyro_mul, gyro_prod_reg;
    logic signed [VEL_WIDTH+COEF_W-1:0]    vy_mul, vy_prod_reg;

    // Q.16 wheel sums
    logic signed [Q_W-1:0] vx_q, vr_q, common_q, half_q, vyp_q;
    logic signed [Q_W-1:0] q_next [NUM_WHEELS];
    logic signed [Q_W-1:0] q_reg  [NUM_WHEELS];

    // Truncate and clamp
    logic signed [T_W-1:0] t_shift [NUM_WHEELS];
    logic signed [T_W-1:0] t_val   [NUM_WHEELS];
    logic signed [T_W-1:0] w_val   [NUM_WHEELS];
    logic signed [T_W-1:0] lim_s, neg_lim;
    logic [LIM_W-1:0]      mag_next [NUM_WHEELS];
    logic [LIM_W-1:0]      mag_reg  [NUM_WHEELS];
    logic [NUM_WHEELS-1:0] dir_next, dir_reg;
    logic                  all_zero;

    // Idle tracking
    logic [IDLE_W-1:0] idle_count_reg, idle_count_next;
    logic              idle_dis_reg, idle_dis_next;
    logic              enable_reg, enable_next;
    logic [IDLE_W:0]   idle_inc;
    logic              dis_mid;

    // Divider and periods
    logic             div_done;
    logic [NUM_W-1:0] div_quot;
    logic [PER_W-1:0] period_reg [NUM_WHEELS];
    logic [PER_W-1:0] period_sat;

    out_beat_t out_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gyro_gain_reg   <= RST_GYRO_GAIN;
            drive_limit_reg <= RST_DRIVE_LIMIT;
            low_voltage_reg <= RST_LOW_VOLTAGE;
            idle_limit_reg  <= RST_IDLE_LIMIT;
            period_num_reg  <= RST_PERIOD_NUMERATOR;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GYRO_GAIN:        gyro_gain_reg   <= cfg_data[GAIN_W-1:0];
                CFG_DRIVE_LIMIT:      drive_limit_reg <= cfg_data[LIM_W-1:0];
                CFG_LOW_VOLTAGE:      low_voltage_reg <= cfg_data[VOLT_W-1:0];
                CFG_IDLE_LIMIT:       idle_limit_reg  <= cfg_data[IDLE_W-1:0];
                CFG_PERIOD_NUMERATOR: period_num_reg  <= cfg_data[NUM_W-1:0];
                default:              ;
            endcase
        end
    end

    // Capture the input beat
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            vx_reg   <= in_beat.vel_x;
            vy_reg   <= in_beat.vel_y;
            vr_reg   <= in_beat.vel_rot;
            gz_reg   <= in_beat.gyro_z;
            volt_reg <= in_beat.battery_voltage;
        end
    end

    assign stat.low_batt = volt_reg < low_voltage_reg;
    assign stat.div_done = div_done;

    // Gyro compensation and the sqrt(3)/2 term
    assign gyro_mul = gz_reg * $signed({1'b0, gyro_gain_reg});
    assign vy_mul   = vy_reg * COEF_SQRT3_2;

    always_ff @(posedge clk)
    begin
        if (cmd.mult)
        begin
            gyro_prod_reg <= gyro_mul;
            vy_prod_reg   <= vy_mul;
        end
    end

    // Form the three Q.16 wheel sums
    assign vx_q     = Q_W'(vx_reg);
    assign vr_q     = Q_W'(vr_reg);
    assign vyp_q    = Q_W'(vy_prod_reg);
    assign half_q   = vx_q <<< 15;
    assign common_q = (vr_q <<< 16) + Q_W'(gyro_prod_reg);

    always_comb
    begin
        q_next[0] = (vx_q <<< 16) + common_q;
        q_next[1] = common_q - half_q + vyp_q;
        q_next[2] = common_q - half_q - vyp_q;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum)
        begin
            for (int i = 0; i < NUM_WHEELS; i++)
            begin
                q_reg[i] <= q_next[i];
            end
        end
    end

    // Truncate toward zero, clamp, split into magnitude and direction
    assign lim_s   = $signed({{(T_W-LIM_W){1'b0}}, drive_limit_reg});
    assign neg_lim = -lim_s;

    always_comb
    begin
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            t_shift[i] = T_W'(q_reg[i] >>> 16);
            if (q_reg[i][Q_W-1] && (q_reg[i][15:0] != 16'd0))
            begin
                t_val[i] = t_shift[i] + T_W'(1);
            end
            else
            begin
                t_val[i] = t_shift[i];
            end
            if (t_val[i] > lim_s)
            begin
                w_val[i] = lim_s;
            end
            else if (t_val[i] < neg_lim)
            begin
                w_val[i] = neg_lim;
            end
            else
            begin
                w_val[i] = t_val[i];
            end
            mag_next[i] = w_val[i][T_W-1] ? LIM_W'(-w_val[i]) : LIM_W'(w_val[i]);
            dir_next[i] = !(w_val[i] > T_W'(0));
        end
    end

    assign all_zero = (t_val[0] == T_W'(0)) && (t_val[1] == T_W'(0))
                   && (t_val[2] == T_W'(0));

    // Advance the idle counter; disable after too many still ticks
    assign idle_inc = all_zero ? ({1'b0, idle_count_reg} + (IDLE_W+1)'(1)) : '0;

    always_comb
    begin
        idle_count_next = idle_count_reg;
        idle_dis_next   = idle_dis_reg;
        enable_next     = enable_reg;
        dis_mid         = idle_dis_reg;
        if (cmd.clamp)
        begin
            if (!idle_dis_reg)
            begin
                if (idle_inc > {1'b0, idle_limit_reg})
                begin
                    dis_mid         = 1'b1;
                    idle_count_next = '0;
                end
                else
                begin
                    dis_mid         = 1'b0;
                    idle_count_next = idle_inc[IDLE_W-1:0];
                end
            end
            enable_next   = !dis_mid;
            idle_dis_next = dis_mid && all_zero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_count_reg <= '0;
            idle_dis_reg   <= 1'b0;
            enable_reg     <= 1'b0;
        end
        else
        begin
            idle_count_reg <= idle_count_next;
            idle_dis_reg   <= idle_dis_next;
            enable_reg     <= enable_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clamp)
        begin
            for (int i = 0; i < NUM_WHEELS; i++)
            begin
                mag_reg[i] <= mag_next[i];
            end
            dir_reg <= dir_next;
        end
    end

    // Shared divider: numerator over wheel magnitude. A zero magnitude
    // yields an all-ones quotient, which saturates to the maximum period.
    owd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (period_num_reg),
        .divisor  (mag_reg[cmd.wheel]),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign period_sat = (|div_quot[NUM_W-1:PER_W]) ? PERIOD_MAX : div_quot[PER_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.quot_store)
        begin
            period_reg[cmd.wheel] <= period_sat;
        end
    end

    // Load the output beat
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (cmd.out_off)
            begin
                out_reg.period_a      <= '0;
                out_reg.period_b      <= '0;
                out_reg.period_c      <= '0;
                out_reg.dir_a         <= 1'b0;
                out_reg.dir_b         <= 1'b0;
                out_reg.dir_c         <= 1'b0;
                out_reg.driver_enable <= 1'b0;
                out_reg.shutdown      <= 1'b1;
            end
            else
            begin
                out_reg.period_a      <= period_reg[0];
                out_reg.period_b      <= period_reg[1];
                out_reg.period_c      <= period_reg[2];
                out_reg.dir_a         <= dir_reg[0];
                out_reg.dir_b         <= dir_reg[1];
                out_reg.dir_c         <= dir_reg[2];
                out_reg.driver_enable <= enable_reg;
                out_reg.shutdown      <= 1'b0;
            end
        end
    end

    assign out_beat = out_reg;

endmodule

`default_nettype wire

// ===== rtl/owd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module owd_ctrl (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  wire logic         out_ready,
    output owd_pkg::dp_cmd_t  cmd,
    input  wire owd_pkg::dp_stat_t stat
);
    import owd_pkg::*;

    state_t             state_reg, state_next;
    logic [WHEEL_W-1:0] wheel_reg, wheel_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_free;

    assign out_free = !out_valid_reg || out_ready;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        wheel_next = wheel_reg;
        cmd        = '0;
        cmd.wheel  = wheel_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MULT;
                end
            end
            ST_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = stat.low_batt ? ST_OUT_OFF : ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                wheel_next = WHEEL_A;
                state_next = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.quot_store = 1'b1;
                    if (wheel_reg == WHEEL_C)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        wheel_next = wheel_reg + WHEEL_W'(1);
                        state_next = ST_DIV_START;
                    end
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_OUT_OFF:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_off  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result until the sink takes the beat
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wheel_reg     <= WHEEL_A;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wheel_reg     <= wheel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd.out_load)
        else $error("output beat overwritten");

    // Divider completion arrives only while waiting for it
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |-> (state_reg == ST_DIV_WAIT))
        else $error("unexpected divider done");

    // An accepted beat starts the multiply stage
    a_accept_to_mult: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_MULT))
        else $error("accepted beat not processed");

    // Wheel index stays within the three wheels
    a_wheel_range: assert property (@(posedge clk) disable iff (!rst_n)
        wheel_reg <= WHEEL_C)
        else $error("wheel index out of range");

endmodule

`default_nettype wire

// ===== rtl/omni_wheel_drive_output.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel     Role    Beat
// vel_in      sink    vel_x, vel_y, vel_rot, gyro_z, battery_voltage
// drive_out   source  period_a/b/c, dir_a/b/c, driver_enable, shutdown
// cfg         write   cfg_we, cfg_index, cfg_data (no read-back)
//
// Each beat runs three pipeline steps (multiply, sum, truncate and clamp),
// then uses the one shared bit-serial divider (24 quotient bits) for each
// wheel in turn, then the output load. A low-battery beat goes from the
// multiply step straight to a shutdown output load. Reset is asynchronous,
// active low, and restores register defaults and clears idle tracking.
// A finished beat waits in the output register; a new beat is taken meanwhile.

module omni_wheel_drive_output (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    owd_in_if.sink                              vel_in,
    owd_out_if.source                           drive_out,
    input  wire logic                           cfg_we,
    input  wire logic [owd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [owd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import owd_pkg::*;

    dp_cmd_t   cmd;
    dp_stat_t  stat;
    in_beat_t  in_beat;
    out_beat_t out_beat;
    logic      in_ready;
    logic      out_valid;

    // Gather the input beat
    always_comb
    begin
        in_beat.vel_x           = vel_in.vel_x;
        in_beat.vel_y           = vel_in.vel_y;
        in_beat.vel_rot         = vel_in.vel_rot;
        in_beat.gyro_z          = vel_in.gyro_z;
        in_beat.battery_voltage = vel_in.battery_voltage;
    end

    assign vel_in.ready = in_ready;

    owd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vel_in.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (drive_out.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    owd_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_beat   (in_beat),
        .out_beat  (out_beat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Drive the output beat
    assign drive_out.valid         = out_valid;
    assign drive_out.period_a      = out_beat.period_a;
    assign drive_out.period_b      = out_beat.period_b;
    assign drive_out.period_c      = out_beat.period_c;
    assign drive_out.dir_a         = out_beat.dir_a;
    assign drive_out.dir_b         = out_beat.dir_b;
    assign drive_out.dir_c         = out_beat.dir_c;
    assign drive_out.driver_enable = out_beat.driver_enable;
    assign drive_out.shutdown      = out_beat.shutdown;

endmodule

`default_nettype wire

// ===== tb/owd_drive_checker.sv =====
`timescale 1ns / 1ps

module owd_drive_checker
    import owd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    owd_in_if                     vel_mon,
    owd_out_if                    drive_mon,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    cmds_in_flight,
    output int                    error_total
);

    // Q.16 kinematic weights
    localparam longint Q16_ONE        = 65536;
    localparam longint HALF_Q16       = 32768;
    localparam longint SQRT3_HALF_Q16 = 56756;
    localparam longint PERIOD_SAT     = 65535;

    // Shadow copy of the register file
    logic [GAIN_W-1:0] gain_q16;
    logic [LIM_W-1:0]  wheel_limit;
    logic [VOLT_W-1:0] batt_floor;
    logic [IDLE_W-1:0] idle_ticks_max;
    logic [NUM_W-1:0]  step_numer;

    // Idle tracking
    int unsigned zero_run;
    logic        parked;

    // Wheel commands still owed by the block
    out_beat_t wheel_cmd_q[$];

    initial error_total = 0;

    function automatic logic [PER_W-1:0] step_period(input longint wheel);
        longint mag;
        longint quot;
        mag = (wheel < 0) ? -wheel : wheel;
        if (mag == 0)
            return PER_W'(PERIOD_SAT);
        quot = longint'(step_numer) / mag;
        return (quot > PERIOD_SAT) ? PER_W'(PERIOD_SAT) : PER_W'(quot);
    endfunction

    function automatic longint clamp_wheel(input longint target);
        longint lim;
        lim = longint'(wheel_limit);
        if (target > lim)
            return lim;
        if (target < -lim)
            return -lim;
        return target;
    endfunction

    // Work out one wheel command and advance the idle tracking
    function automatic out_beat_t predict_drive(input in_beat_t b);
        longint    vx, vy, vr, gz, common;
        longint    ta, tb, tc, wa, wb, wc;
        int unsigned next_run;
        logic      all_zero;
        logic      enable;
        out_beat_t r;
        r = '0;
        if (b.battery_voltage < batt_floor) begin
            r.shutdown = 1'b1;
            return r;
        end
        vx = longint'($signed(b.vel_x));
        vy = longint'($signed(b.vel_y));
        vr = longint'($signed(b.vel_rot));
        gz = longint'($signed(b.gyro_z));
        common = vr * Q16_ONE + gz * longint'(gain_q16);
        // signed division truncates toward zero
        ta = (vx * Q16_ONE + common) / Q16_ONE;
        tb = (-vx * HALF_Q16 + vy * SQRT3_HALF_Q16 + common) / Q16_ONE;
        tc = (-vx * HALF_Q16 - vy * SQRT3_HALF_Q16 + common) / Q16_ONE;
        wa = clamp_wheel(ta);
        wb = clamp_wheel(tb);
        wc = clamp_wheel(tc);

        // idle test works on the unclamped targets
        all_zero = (ta == 0) && (tb == 0) && (tc == 0);
        enable = 1'b1;
        if (!parked) begin
            next_run = all_zero ? zero_run + 1 : 0;
            if (next_run > idle_ticks_max) begin
                parked = 1'b1;
                zero_run = 0;
            end else begin
                zero_run = next_run;
            end
        end
        if (parked) begin
            enable = 1'b0;
            if (!all_zero)
                parked = 1'b0;
        end

        r.period_a      = step_period(wa);
        r.period_b      = step_period(wb);
        r.period_c      = step_period(wc);
        r.dir_a         = (wa > 0) ? 1'b0 : 1'b1;
        r.dir_b         = (wb > 0) ? 1'b0 : 1'b1;
        r.dir_c         = (wc > 0) ? 1'b0 : 1'b1;
        r.driver_enable = enable;
        r.shutdown      = 1'b0;
        return r;
    endfunction

    function automatic bit field_ok(input string name, input int unsigned want,
                                    input int unsigned got);
        if (want == got)
            return 1'b1;
        $error("%s: expected %0d, got %0d", name, want, got);
        return 1'b0;
    endfunction

    // Track config, compare each drive beat, predict each velocity beat
    always @(posedge clk or negedge rst_n)
    begin : watch
        in_beat_t  vel_beat;
        out_beat_t got, want;
        bit        ok;
        if (!rst_n)
        begin
            gain_q16       <= RST_GYRO_GAIN;
            wheel_limit    <= RST_DRIVE_LIMIT;
            batt_floor     <= RST_LOW_VOLTAGE;
            idle_ticks_max <= RST_IDLE_LIMIT;
            step_numer     <= RST_PERIOD_NUMERATOR;
            zero_run       = 0;
            parked         = 1'b0;
            wheel_cmd_q.delete();
            cmds_in_flight <= 0;
        end
        else
        begin
            // Capture register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GYRO_GAIN:        gain_q16       <= cfg_data[GAIN_W-1:0];
                    CFG_DRIVE_LIMIT:      wheel_limit    <= cfg_data[LIM_W-1:0];
                    CFG_LOW_VOLTAGE:      batt_floor     <= cfg_data[VOLT_W-1:0];
                    CFG_IDLE_LIMIT:       idle_ticks_max <= cfg_data[IDLE_W-1:0];
                    CFG_PERIOD_NUMERATOR: step_numer     <= cfg_data[NUM_W-1:0];
                    default: ;
                endcase
            end

            // Compare the drive beat with the oldest prediction
            if (drive_mon.valid && drive_mon.ready)
            begin
                got.period_a      = drive_mon.period_a;
                got.period_b      = drive_mon.period_b;
                got.period_c      = drive_mon.period_c;
                got.dir_a         = drive_mon.dir_a;
                got.dir_b         = drive_mon.dir_b;
                got.dir_c         = drive_mon.dir_c;
                got.driver_enable = drive_mon.driver_enable;
                got.shutdown      = drive_mon.shutdown;
                if (wheel_cmd_q.size() == 0)
                begin
                    $error("drive beat with no command outstanding");
                    error_total = error_total + 1;
                end
                else
                begin
                    want = wheel_cmd_q.pop_front();
                    ok = 1'b1;
                    ok &= field_ok("period_a", want.period_a, got.period_a);
                    ok &= field_ok("period_b", want.period_b, got.period_b);
                    ok &= field_ok("period_c", want.period_c, got.period_c);
                    ok &= field_ok("dir_a", want.dir_a, got.dir_a);
                    ok &= field_ok("dir_b", want.dir_b, got.dir_b);
                    ok &= field_ok("dir_c", want.dir_c, got.dir_c);
                    ok &= field_ok("driver_enable", want.driver_enable,
                                   got.driver_enable);
                    ok &= field_ok("shutdown", want.shutdown, got.shutdown);
                    if (!ok)
                        error_total = error_total + 1;
                end
            end

            // Predict the command for an accepted velocity beat
            if (vel_mon.valid && vel_mon.ready)
            begin
                vel_beat.vel_x           = vel_mon.vel_x;
                vel_beat.vel_y           = vel_mon.vel_y;
                vel_beat.vel_rot         = vel_mon.vel_rot;
                vel_beat.gyro_z          = vel_mon.gyro_z;
                vel_beat.battery_voltage = vel_mon.battery_voltage;
                wheel_cmd_q.push_back(predict_drive(vel_beat));
            end

            cmds_in_flight <= wheel_cmd_q.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import owd_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 5;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_CYCLES  = 1500;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int          cmds_in_flight;
    int          error_total;
    int          src_idle_pct;
    int          snk_idle_pct;
    int          hold_request;
    int unsigned cur_low;
    int unsigned cycle_count;

    owd_in_if  vel_ch ();
    owd_out_if drive_ch ();

    omni_wheel_drive_output DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .vel_in    (vel_ch),
        .drive_out (drive_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    owd_drive_checker u_drive_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .vel_mon        (vel_ch),
        .drive_mon      (drive_ch),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmds_in_flight (cmds_in_flight),
        .error_total    (error_total)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Abort a hung run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // Drive ready: random stalls, or a long hold when asked for one
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                drive_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                drive_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    function automatic in_beat_t make_beat(input int x, input int y, input int r,
                                           input int g, input int v);
        in_beat_t b;
        b.vel_x           = VEL_WIDTH'(x);
        b.vel_y           = VEL_WIDTH'(y);
        b.vel_rot         = VEL_WIDTH'(r);
        b.gyro_z          = GYRO_W'(g);
        b.battery_voltage = VOLT_W'(v);
        return b;
    endfunction

    function automatic logic [VOLT_W-1:0] healthy_volts();
        return VOLT_W'($urandom_range(65535, cur_low));
    endfunction

    // Targets that truncate to zero on every wheel, or very nearly
    function automatic in_beat_t quiet_beat();
        return make_beat(0, int'($urandom_range(2)) - 1, 0,
                         int'($urandom_range(2)) - 1, healthy_volts());
    endfunction

    function automatic in_beat_t random_beat();
        int unsigned pick;
        in_beat_t    b;
        pick = $urandom_range(99);
        b = make_beat($urandom, $urandom, $urandom, $urandom, healthy_volts());
        if (pick < 45)
        begin
            b.vel_x   = VEL_WIDTH'($urandom_range(8000) - 4000);
            b.vel_y   = VEL_WIDTH'($urandom_range(8000) - 4000);
            b.vel_rot = VEL_WIDTH'($urandom_range(8000) - 4000);
        end
        else if (pick >= 85 && cur_low > 0)
            b.battery_voltage = VOLT_W'($urandom_range(cur_low - 1, 0));
        return b;
    endfunction

    // Offer one beat and hold it until taken; returns on a falling edge
    task automatic send_beat(input in_beat_t b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            vel_ch.valid <= 1'b0;
            @(negedge clk);
        end
        vel_ch.valid           <= 1'b1;
        vel_ch.vel_x           <= b.vel_x;
        vel_ch.vel_y           <= b.vel_y;
        vel_ch.vel_rot         <= b.vel_rot;
        vel_ch.gyro_z          <= b.gyro_z;
        vel_ch.battery_voltage <= b.battery_voltage;
        do
            @(posedge clk);
        while (!vel_ch.ready);
        @(negedge clk);
    endtask

    // Drop valid and wait for every owed command to come out
    task automatic wait_drained();
        vel_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (cmds_in_flight != 0);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(negedge clk);
    endtask

    task automatic apply_settings(input int unsigned gain, input int unsigned lim,
                                  input int unsigned lowv, input int unsigned ilim,
                                  input int unsigned numer);
        cfg_write(CFG_GYRO_GAIN, gain);
        cfg_write(CFG_DRIVE_LIMIT, lim);
        cfg_write(CFG_LOW_VOLTAGE, lowv);
        cfg_write(CFG_IDLE_LIMIT, ilim);
        cfg_write(CFG_PERIOD_NUMERATOR, numer);
        cfg_we  <= 1'b0;
        cur_low = lowv;
    endtask

    // Mix bursts of zero ticks with ordinary commands
    task automatic run_items(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(99) < 30)
            begin
                burst = $urandom_range(12, 1);
                repeat (burst) send_beat(quiet_beat());
                sent += burst;
            end
            else
            begin
                send_beat(random_beat());
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = CFG_GYRO_GAIN;
        cfg_data               = '0;
        vel_ch.valid           = 1'b0;
        vel_ch.vel_x           = '0;
        vel_ch.vel_y           = '0;
        vel_ch.vel_rot         = '0;
        vel_ch.gyro_z          = '0;
        vel_ch.battery_voltage = '0;
        drive_ch.ready         = 1'b0;
        hold_request           = 0;
        src_idle_pct           = 35;
        snk_idle_pct           = 80;
        cur_low                = RST_LOW_VOLTAGE;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Register defaults: field extremes, battery threshold, tiny speeds
        send_beat(make_beat(0, 0, 0, 0, 5000));
        send_beat(make_beat(32767, 0, 0, 0, 5000));
        send_beat(make_beat(-32768, 0, 0, 0, 5000));
        send_beat(make_beat(0, 32767, 0, 0, 5000));
        send_beat(make_beat(0, -32768, 0, 0, 5000));
        send_beat(make_beat(0, 0, 32767, 0, 5000));
        send_beat(make_beat(0, 0, -32768, 0, 5000));
        send_beat(make_beat(0, 0, 0, 32767, 5000));
        send_beat(make_beat(0, 0, 0, -32768, 5000));
        send_beat(make_beat(1, 0, 0, 0, 1100));
        send_beat(make_beat(-1, 1, 0, 0, 2000));
        send_beat(make_beat(0, -1, 0, 0, 2000));
        send_beat(make_beat(400, 0, 0, 0, 65535));
        send_beat(make_beat(100, 0, -100, 0, 3000));
        send_beat(make_beat(200, 300, -50, 1000, 1099));
        send_beat(make_beat(32767, 32767, 32767, 32767, 0));
        send_beat(make_beat(32767, 32767, 32767, 32767, 65535));
        send_beat(make_beat(-32768, -32768, -32768, -32768, 65535));
        send_beat(make_beat(-5, 7, 3, -2000, 12000));
        send_beat(make_beat(0, 0, 0, 1, 4000));
        wait_drained();

        // Short idle limit, with a long output stall part way through
        apply_settings(262, 5000, 1100, 3, 1000000);
        run_items(30);
        hold_request = HOLD_CYCLES;
        run_items(120);
        wait_drained();

        // Upper extremes: park on the first zero tick
        apply_settings(65535, 32767, 0, 0, 16777215);
        run_items(100);
        wait_drained();

        // Lower extremes: zero clamp, with the battery threshold at its maximum
        src_idle_pct = 80;
        snk_idle_pct = 35;
        apply_settings(0, 0, 65535, 1023, 1);
        run_items(60);
        wait_drained();

        // Random settings, with a full drain mid-stream
        apply_settings($urandom_range(65535), $urandom_range(32767),
                       $urandom_range(3000), $urandom_range(7),
                       $urandom_range(16777215, 1));
        run_items(70);
        wait_drained();
        run_items(80);
        wait_drained();

        // Small numerator drives periods to zero; no stalls either side
        src_idle_pct = 0;
        snk_idle_pct = 0;
        apply_settings(1000, 200, 500, 2, 50);
        run_items(140);
        wait_drained();

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_total == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
